@@ rtl/brd_pkg.sv @@
// brd_pkg: shared types, codes and sizes of the blocked record deframer
// no dependencies; imported by every module of the block except the generic queue
`timescale 1ns / 1ps

package brd_pkg;

  // default sizes handed to the top level parameters
  localparam int CountBitsDef  = 40;
  localparam int QueueDepthDef = 2;

  // register and field widths
  localparam int TotalW      = 40;
  localparam int ElemBytesW  = 10;
  localparam int MaxRecW     = 16;
  localparam int CfgDataW    = 40;
  localparam int CfgIdxW     = 2;
  localparam int ByteW       = 8;
  localparam int StatusW     = 3;

  // record markers and the count divider
  localparam int HeadBits    = 32;
  localparam int DivBits     = HeadBits - 1;
  localparam int DivCntW     = $clog2(DivBits);
  localparam int MarkerIdxW  = 2;
  localparam logic [MarkerIdxW-1:0] MarkerLast = 2'd3;

  // register reset values
  localparam logic [TotalW-1:0]     TotalRst     = 40'd1;
  localparam logic [ElemBytesW-1:0] ElemBytesRst = 10'd4;
  localparam logic [MaxRecW-1:0]    MaxRecRst    = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL       = 2'd0,
    CFG_ELEM_BYTES  = 2'd1,
    CFG_MAX_PER_REC = 2'd2
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_DATA          = 3'd0,
    ST_DONE          = 3'd1,
    ST_BAD_COUNT     = 3'd2,
    ST_WRONG_NUM     = 3'd3,
    ST_TAIL_MISMATCH = 3'd4
  } status_e;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0]      out_byte;
    logic [ElemBytesW-1:0] byte_in_element;
    logic                  last_of_element;
    logic                  last_of_record;
    status_e               status;
  } out_t;

  // classified request handed from the front to the back
  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } cmd_t;

endpackage

@@ rtl/brd_fifo.sv @@
// brd_fifo: small first-word-fall-through queue of any width
// no dependencies; used for the command queue and the result queue
`timescale 1ns / 1ps

module brd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/brd_front.sv @@
// brd_front: takes input requests, classifies them and queues them for the back
// depends on brd_pkg and brd_fifo
`timescale 1ns / 1ps

module brd_front #(
  parameter int QUEUE_DEPTH = brd_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  brd_pkg::in_t in_i,
  output logic         full_o,
  output logic         cmd_valid_o,
  output brd_pkg::cmd_t cmd_o,
  input  logic         cmd_pop_i
);

  import brd_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  // restart or plain stream byte
  always_comb begin
    cmd_in.op   = in_i.action ? OP_RESTART : OP_BYTE;
    cmd_in.data = in_i.in_byte;
  end

  brd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty),
    .rdata_o (cmd_o)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

@@ rtl/brd_div.sv @@
// brd_div: restoring divider, one quotient bit per cycle, for the record byte count
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [brd_pkg::DivBits-1:0]        dividend_i,
  input  logic [brd_pkg::ElemBytesW-1:0]     divisor_i,
  output logic                               busy_o,
  output logic [brd_pkg::DivBits-1:0]        quotient_o
);

  import brd_pkg::*;

  logic                  busy_q, busy_d;
  logic [DivCntW-1:0]    cnt_q, cnt_d;
  logic [ElemBytesW-1:0] rem_q, rem_d;
  logic [DivBits-1:0]    quo_q, quo_d;
  logic [ElemBytesW:0]   trial;
  logic                  q_bit;

  // quo_q shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {rem_q, quo_q[DivBits-1]};
  assign q_bit = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivBits - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = q_bit ? ElemBytesW'(trial - {1'b0, divisor_i}) : trial[ElemBytesW-1:0];
      quo_d = {quo_q[DivBits-2:0], q_bit};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/brd_back.sv @@
// brd_back: record state machine; walks heads, element data and tails, reports status
// depends on brd_pkg and brd_div
`timescale 1ns / 1ps

module brd_back #(
  parameter int COUNT_BITS = brd_pkg::CountBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  brd_pkg::cmd_t                  cmd_i,
  output logic                           cmd_pop_o,
  input  logic [brd_pkg::TotalW-1:0]     total_i,
  input  logic [brd_pkg::ElemBytesW-1:0] elem_bytes_i,
  input  logic [brd_pkg::MaxRecW-1:0]    max_per_rec_i,
  input  logic                           res_full_i,
  output logic                           res_push_o,
  output brd_pkg::out_t                  res_o
);

  import brd_pkg::*;

  localparam int CmpW = (COUNT_BITS > DivBits) ? COUNT_BITS : DivBits;

  typedef enum logic [7:0] {
    PH_HEAD      = 8'b0000_0001,
    PH_DIV       = 8'b0000_0010,
    PH_DATA      = 8'b0000_0100,
    PH_TAIL      = 8'b0000_1000,
    PH_DONE      = 8'b0001_0000,
    PH_ERR_COUNT = 8'b0010_0000,
    PH_ERR_NUM   = 8'b0100_0000,
    PH_ERR_TAIL  = 8'b1000_0000
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [MarkerIdxW-1:0] mbi_q, mbi_d;
  logic [HeadBits-1:0]   head_q, head_d;
  logic [HeadBits-1:0]   tail_q, tail_d;
  logic [MaxRecW-1:0]    rel_q, rel_d;
  logic [ElemBytesW-1:0] ebi_q, ebi_d;
  logic [COUNT_BITS-1:0] left_q, left_d;

  logic                  div_start;
  logic                  div_busy;
  logic [DivBits-1:0]    quo;
  logic [CmpW-1:0]       num_w, left_w;
  logic [DivBits-1:0]    max_w;
  logic [COUNT_BITS-1:0] restart_left;
  logic                  last_el, last_rec;

  brd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (head_d[DivBits-1:0]),
    .divisor_i  (elem_bytes_i),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign num_w        = CmpW'(quo);
  assign left_w       = CmpW'(left_q);
  assign max_w        = DivBits'(max_per_rec_i);
  assign restart_left = COUNT_BITS'(total_i);
  assign last_el      = ({1'b0, ebi_q} + 1'b1) >= {1'b0, elem_bytes_i};
  assign last_rec     = last_el && (rel_q <= MaxRecW'(1));

  always_comb begin
    phase_d    = phase_q;
    mbi_d      = mbi_q;
    head_d     = head_q;
    tail_d     = tail_q;
    rel_d      = rel_q;
    ebi_d      = ebi_q;
    left_d     = left_q;
    div_start  = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;

    if (phase_q == PH_DIV) begin
      // element count known: range checks against the record maximum and what is due
      if (!div_busy && !res_full_i) begin
        if (quo > max_w) begin
          phase_d      = PH_ERR_COUNT;
          res_push_o   = 1'b1;
          res_o.status = ST_BAD_COUNT;
        end else if (((quo < max_w) && (num_w != left_w)) ||
                     ((quo == max_w) && (num_w > left_w))) begin
          phase_d      = PH_ERR_NUM;
          res_push_o   = 1'b1;
          res_o.status = ST_WRONG_NUM;
        end else begin
          left_d  = left_q - COUNT_BITS'(quo[MaxRecW-1:0]);
          rel_d   = quo[MaxRecW-1:0];
          ebi_d   = '0;
          tail_d  = '0;
          phase_d = (quo == '0) ? PH_TAIL : PH_DATA;
        end
      end
    end else if (cmd_valid_i && !res_full_i) begin
      cmd_pop_o = 1'b1;
      if (cmd_i.op == OP_RESTART) begin
        mbi_d  = '0;
        head_d = '0;
        tail_d = '0;
        rel_d  = '0;
        ebi_d  = '0;
        left_d = restart_left;
        if (restart_left == '0) begin
          phase_d      = PH_DONE;
          res_push_o   = 1'b1;
          res_o.status = ST_DONE;
        end else begin
          phase_d = PH_HEAD;
        end
      end else begin
        case (phase_q)
          PH_HEAD: begin
            head_d = {head_q[HeadBits-ByteW-1:0], cmd_i.data};
            if (mbi_q != MarkerLast) begin
              mbi_d = mbi_q + 1'b1;
            end else begin
              mbi_d = '0;
              if (head_d[HeadBits-1]) begin
                phase_d      = PH_ERR_COUNT;
                res_push_o   = 1'b1;
                res_o.status = ST_BAD_COUNT;
              end else begin
                div_start = 1'b1;
                phase_d   = PH_DIV;
              end
            end
          end
          PH_DATA: begin
            res_push_o            = 1'b1;
            res_o.out_byte        = cmd_i.data;
            res_o.byte_in_element = ebi_q;
            res_o.last_of_element = last_el;
            res_o.last_of_record  = last_rec;
            res_o.status          = ST_DATA;
            if (last_el) begin
              ebi_d = '0;
              if (rel_q != '0) begin
                rel_d = rel_q - 1'b1;
              end
              if (last_rec) begin
                rel_d   = '0;
                phase_d = PH_TAIL;
              end
            end else begin
              ebi_d = ebi_q + 1'b1;
            end
          end
          PH_TAIL: begin
            tail_d = {tail_q[HeadBits-ByteW-1:0], cmd_i.data};
            if (mbi_q != MarkerLast) begin
              mbi_d = mbi_q + 1'b1;
            end else begin
              mbi_d = '0;
              if (tail_d != head_q) begin
                phase_d      = PH_ERR_TAIL;
                res_push_o   = 1'b1;
                res_o.status = ST_TAIL_MISMATCH;
              end else if (left_q == '0) begin
                phase_d      = PH_DONE;
                res_push_o   = 1'b1;
                res_o.status = ST_DONE;
              end else begin
                head_d  = '0;
                phase_d = PH_HEAD;
              end
            end
          end
          PH_DONE: begin
            res_push_o   = 1'b1;
            res_o.status = ST_DONE;
          end
          PH_ERR_COUNT: begin
            res_push_o   = 1'b1;
            res_o.status = ST_BAD_COUNT;
          end
          PH_ERR_NUM: begin
            res_push_o   = 1'b1;
            res_o.status = ST_WRONG_NUM;
          end
          default: begin
            phase_d      = PH_ERR_TAIL;
            res_push_o   = 1'b1;
            res_o.status = ST_TAIL_MISMATCH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      mbi_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      rel_q   <= '0;
      ebi_q   <= '0;
      left_q  <= COUNT_BITS'(TotalRst);
    end else begin
      phase_q <= phase_d;
      mbi_q   <= mbi_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      rel_q   <= rel_d;
      ebi_q   <= ebi_d;
      left_q  <= left_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_no_pop_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIV) |-> !cmd_pop_o)
    else $error("request taken while the count divider runs");

  a_div_runs_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (div_busy && phase_q == PH_DIV))
    else $error("divider not busy after head completed");

  a_status_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.status != ST_DATA) |->
      (res_o.out_byte == '0 && res_o.byte_in_element == '0 &&
       !res_o.last_of_element && !res_o.last_of_record))
    else $error("status result carries data fields");

  a_record_end_is_element_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last_of_record) |-> res_o.last_of_element)
    else $error("record ended inside an element");

endmodule

@@ rtl/blocked_record_deframer.sv @@
// blocked_record_deframer: top level; configuration registers, front, back, result queue
// depends on brd_pkg, brd_fifo, brd_front, brd_back
`timescale 1ns / 1ps

// how to use the block
//  - input side is a queue: drive in_i and raise push; the request is taken at a clock
//    edge where push is high and full is low. action 1 restarts a new array, action 0
//    carries one stream byte
//  - result side is a queue: while empty is low the oldest result sits on out_o; it is
//    taken at an edge where pop is high
//  - configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 total
//    elements, 1 element bytes, 2 max elements per record); write only while idle
//  - path: a data byte passes the request queue and then the result queue, both
//    registered, before it is on out_o and can be popped
//  - throughput: one stream byte per cycle in data and marker bytes while the result
//    queue has room; after the fourth byte of a non-negative record head the count
//    divider runs, one quotient bit per cycle, and the checks follow once it is idle;
//    only then is the next request taken (the front still queues)
//  - reset: registers go to 1 / 4 / 1000, both queues empty, waiting for a record head
//  - receiver stall: the result queue fills, the back end stops, the request queue fills
//    and full rises; nothing is dropped
module blocked_record_deframer #(
  parameter int COUNT_BITS  = brd_pkg::CountBitsDef,
  parameter int QUEUE_DEPTH = brd_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request queue
  input  logic                         push,
  input  brd_pkg::in_t                 in_i,
  output logic                         full,
  // result queue
  output logic                         empty,
  input  logic                         pop,
  output brd_pkg::out_t                out_o,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [brd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [brd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  import brd_pkg::*;

  // configuration registers
  logic [TotalW-1:0]     total_q;
  logic [ElemBytesW-1:0] elem_bytes_q;
  logic [MaxRecW-1:0]    max_rec_q;
  logic [ElemBytesW-1:0] elem_bytes_eff;

  // front to back
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // back to result queue
  logic res_push;
  logic res_full;
  out_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= TotalRst;
      elem_bytes_q <= ElemBytesRst;
      max_rec_q    <= MaxRecRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL:       total_q      <= cfg_wdata_i[TotalW-1:0];
        CFG_ELEM_BYTES:  elem_bytes_q <= cfg_wdata_i[ElemBytesW-1:0];
        CFG_MAX_PER_REC: max_rec_q    <= cfg_wdata_i[MaxRecW-1:0];
        default: begin
          // unused index, write ignored
        end
      endcase
    end
  end

  // zero element size counts as one byte
  assign elem_bytes_eff = (elem_bytes_q == '0) ? ElemBytesW'(1) : elem_bytes_q;

  brd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  brd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .total_i       (total_q),
    .elem_bytes_i  (elem_bytes_eff),
    .max_per_rec_i (max_rec_q),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res)
  );

  // result queue parts the back end from the receiver
  brd_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_o)
  );

endmodule
